// ===== hw/rtl/mcsc_pkg.sv =====
package mcsc_pkg;

  localparam int MAX_ITEMS_DEF  = 12;
  localparam int MAX_SKILLS_DEF = 12;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 4;
  localparam int AMT_W     = 16;
  localparam int SUM_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_COST  = 2'd0;
  localparam logic [OP_W-1:0] OP_GAIN  = 2'd1;
  localparam logic [OP_W-1:0] OP_SOLVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ITEMS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SKILLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 2'd2;

  localparam logic [IDX_W-1:0] NUM_ITEMS_RST  = 4'd12;
  localparam logic [IDX_W-1:0] NUM_SKILLS_RST = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] item;
    logic [IDX_W-1:0] skill;
    logic [AMT_W-1:0] amount;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [SUM_W-1:0] min_cost;
  } out_t;

  typedef struct packed {
    logic             wr_cost;
    logic             wr_gain;
    logic             clear;
    logic             step;
    logic             step_add;
    logic [IDX_W-1:0] step_item;
    logic             load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_stat_t;

endpackage

// ===== hw/rtl/min_cost_subset_cover_search.sv =====
// Cost and gain writes are accepted back to back while the search is idle.
// A solve walks all 2^num_items subsets in Gray order, one item flip per cycle
// through a three-stage read/accumulate/compare path; its result beat is loaded
// once that path drains and the result slot frees.
// rst_n is synchronous, active low; it restores the register defaults and
// idles the search. Cost and gain tables are not cleared.
module min_cost_subset_cover_search
  import mcsc_pkg::*;
#(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int MAX_SKILLS = MAX_SKILLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SUM_W-1:0]     cfg_data
);

  logic [IDX_W-1:0] num_items_r, num_items_nxt;
  logic [IDX_W-1:0] num_skills_r, num_skills_nxt;
  logic [SUM_W-1:0] target_r, target_nxt;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    num_items_nxt  = num_items_r;
    num_skills_nxt = num_skills_r;
    target_nxt     = target_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_ITEMS:  num_items_nxt  = cfg_data[IDX_W-1:0];
        CFG_NUM_SKILLS: num_skills_nxt = cfg_data[IDX_W-1:0];
        CFG_TARGET:     target_nxt     = cfg_data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_items_r  <= NUM_ITEMS_RST;
      num_skills_r <= NUM_SKILLS_RST;
      target_r     <= '0;
    end else begin
      num_items_r  <= num_items_nxt;
      num_skills_r <= num_skills_nxt;
      target_r     <= target_nxt;
    end
  end

  mcsc_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.operation),
    .num_items (num_items_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mcsc_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_SKILLS (MAX_SKILLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .num_skills (num_skills_r),
    .target     (target_r),
    .stat       (stat),
    .out_data   (out_data)
  );

endmodule

// ===== hw/rtl/mcsc_ctrl.sv =====
module mcsc_ctrl
  import mcsc_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  in_op,
  input  logic [IDX_W-1:0] num_items,
  output logic             out_valid,
  input  logic             out_ready,
  output ctrl_cmd_t        cmd,
  input  dp_stat_t         stat
);

  localparam int CNT_W = MAX_ITEMS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [IDX_W:0]   items_c;
  logic [CNT_W:0]   limit_c;
  logic [CNT_W-1:0] last_c;
  logic [CNT_W:0]   k_ext;
  logic [IDX_W-1:0] flip_idx;
  logic             flip_add;

  // clamp item count, last Gray step index is 2^items - 1
  always_comb begin
    items_c = ({1'b0, num_items} > (IDX_W+1)'(MAX_ITEMS)) ? (IDX_W+1)'(MAX_ITEMS)
                                                           : {1'b0, num_items};
    limit_c = (CNT_W+1)'(1) << items_c;
    last_c  = CNT_W'(limit_c - (CNT_W+1)'(1));
  end

  // step k toggles bit ctz(k); the item joins when gray(k) has that bit set
  always_comb begin
    k_ext    = {1'b0, k_r};
    flip_idx = '0;
    flip_add = 1'b0;
    for (int i = CNT_W - 1; i >= 0; i--) begin
      if (k_r[i]) begin
        flip_idx = IDX_W'(i);
        flip_add = ~k_ext[i+1];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.wr_cost = in_valid && (in_op == OP_COST);
        cmd.wr_gain = in_valid && (in_op == OP_GAIN);
        if (in_valid && (in_op == OP_SOLVE)) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        k_nxt     = CNT_W'(1);
        state_nxt = (items_c == '0) ? ST_DRAIN : ST_RUN;
      end
      ST_RUN: begin
        cmd.step      = 1'b1;
        cmd.step_item = flip_idx;
        cmd.step_add  = flip_add;
        if (k_r == last_c) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the result slot frees
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/mcsc_dp.sv =====
module mcsc_dp
  import mcsc_pkg::*;
#(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int MAX_SKILLS = MAX_SKILLS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_cmd_t        cmd,
  input  in_t              in_data,
  input  logic [IDX_W-1:0] num_skills,
  input  logic [SUM_W-1:0] target,
  output dp_stat_t         stat,
  output out_t             out_data
);

  localparam int ITEM_AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  logic [AMT_W-1:0] cost_mem [MAX_ITEMS];
  logic [AMT_W-1:0] cost_rd_r;
  logic [AMT_W-1:0] gain_rd_r [MAX_SKILLS];
  logic [SUM_W-1:0] sums_r [MAX_SKILLS];
  logic [SUM_W-1:0] total_r;
  logic [SUM_W-1:0] best_cost_r;
  logic             best_valid_r;
  logic             valid_a_r, valid_b_r;
  logic             add_a_r;
  out_t             out_data_r;

  logic                  item_ok;
  logic [ITEM_AW-1:0]    wr_addr;
  logic [ITEM_AW-1:0]    rd_addr;
  logic [MAX_SKILLS-1:0] lane_ok;
  logic                  qualify;
  logic                  better;

  assign item_ok = ({1'b0, in_data.item} < (IDX_W+1)'(MAX_ITEMS));
  assign wr_addr = in_data.item[ITEM_AW-1:0];
  assign rd_addr = cmd.step_item[ITEM_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_cost && item_ok) begin
      cost_mem[wr_addr] <= in_data.amount;
    end
    if (cmd.step) begin
      cost_rd_r <= cost_mem[rd_addr];
    end
  end

  for (genvar j = 0; j < MAX_SKILLS; j++) begin : g_lane
    logic [AMT_W-1:0] gain_mem [MAX_ITEMS];
    logic             wr_en;
    logic [SUM_W-1:0] gain_ext;

    assign wr_en    = cmd.wr_gain && item_ok && (in_data.skill == IDX_W'(j));
    assign gain_ext = {{(SUM_W-AMT_W){1'b0}}, gain_rd_r[j]};

    always_ff @(posedge clk) begin
      if (wr_en) begin
        gain_mem[wr_addr] <= in_data.amount;
      end
      if (cmd.step) begin
        gain_rd_r[j] <= gain_mem[rd_addr];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.clear) begin
        sums_r[j] <= '0;
      end else if (valid_a_r) begin
        sums_r[j] <= add_a_r ? (sums_r[j] + gain_ext) : (sums_r[j] - gain_ext);
      end
    end

    // lanes past the skill count always pass
    assign lane_ok[j] = ({1'b0, num_skills} <= (IDX_W+1)'(j)) || (sums_r[j] >= target);
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      total_r <= '0;
    end else if (valid_a_r) begin
      total_r <= add_a_r ? (total_r + {{(SUM_W-AMT_W){1'b0}}, cost_rd_r})
                         : (total_r - {{(SUM_W-AMT_W){1'b0}}, cost_rd_r});
    end
    if (cmd.step) begin
      add_a_r <= cmd.step_add;
    end
  end

  assign qualify = &lane_ok;
  assign better  = !best_valid_r || (total_r < best_cost_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r    <= 1'b0;
      valid_b_r    <= 1'b0;
      best_valid_r <= 1'b0;
      best_cost_r  <= '1;
    end else begin
      valid_a_r <= cmd.step;
      // a clear puts the empty subset up for evaluation
      valid_b_r <= cmd.clear | valid_a_r;
      if (cmd.clear) begin
        best_valid_r <= 1'b0;
        best_cost_r  <= '1;
      end else if (valid_b_r && qualify && better) begin
        best_valid_r <= 1'b1;
        best_cost_r  <= total_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.found    <= best_valid_r;
      out_data_r.min_cost <= best_valid_r ? best_cost_r : '0;
    end
  end

  assign stat.busy = valid_a_r | valid_b_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/mcsc_checker.sv =====
module mcsc_checker
  import mcsc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_empty_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.min_cost == '0)
    else $error("min_cost nonzero with found low");

  // a solve closes the input side while the search runs
  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.operation == OP_SOLVE) |=> !in_ready)
    else $error("input taken during search");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind min_cost_subset_cover_search mcsc_checker u_mcsc_checker (.*);

// ===== test/tb_min_cost_subset_cover_search.sv =====
`timescale 1ns / 100ps

module tb_min_cost_subset_cover_search;
  import mcsc_pkg::*;

  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 200;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SUM_W-1:0]     cfg_data = '0;

  min_cost_subset_cover_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // search settings as the block holds them
  logic [IDX_W-1:0] reg_items  = NUM_ITEMS_RST;
  logic [IDX_W-1:0] reg_skills = NUM_SKILLS_RST;
  logic [SUM_W-1:0] reg_target = '0;

  // table contents, updated as beats are accepted
  logic [AMT_W-1:0] cost_mem [MAX_ITEMS_DEF];
  logic [AMT_W-1:0] gain_mem [MAX_ITEMS_DEF][MAX_SKILLS_DEF];

  // entries already queued for writing, so a solve never reads an unwritten one
  bit cost_loaded [MAX_ITEMS_DEF];
  bit gain_loaded [MAX_ITEMS_DEF][MAX_SKILLS_DEF];

  in_t  item_queue[$];
  out_t cover_answers[$];
  out_t next_answer;

  int  n_errors = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_found = 0;
  int  n_cfg_writes = 0;
  int  n_useful = 0;
  int  n_solves = 0;
  int  gap_pct = 20;
  int  in_gap = 0;
  int  out_gap = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  beat_taken = 1'b0;

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int clamp_count(input logic [IDX_W-1:0] n, input int limit);
    return (n > limit) ? limit : int'(n);
  endfunction

  // exhaustive search over every subset of the active items
  function automatic out_t cheapest_cover();
    int   n_it, n_sk, mask, i, j, total, sum, best;
    bit   ok, have;
    out_t res;
    n_it = clamp_count(reg_items, MAX_ITEMS_DEF);
    n_sk = clamp_count(reg_skills, MAX_SKILLS_DEF);
    have = 1'b0;
    best = 0;
    for (mask = 0; mask < (1 << n_it); mask++) begin
      total = 0;
      for (i = 0; i < n_it; i++)
        if (mask[i]) total += cost_mem[i];
      ok = 1'b1;
      for (j = 0; j < n_sk && ok; j++) begin
        sum = 0;
        for (i = 0; i < n_it; i++)
          if (mask[i]) sum += gain_mem[i][j];
        if (sum < reg_target) ok = 1'b0;
      end
      if (ok && (!have || total < best)) begin
        best = total;
        have = 1'b1;
      end
    end
    res.found    = have;
    res.min_cost = have ? best[SUM_W-1:0] : '0;
    return res;
  endfunction

  function automatic void absorb_beat(input in_t b);
    case (b.operation)
      OP_COST: if (b.item < MAX_ITEMS_DEF) cost_mem[b.item] = b.amount;
      OP_GAIN: begin
        if (b.item < MAX_ITEMS_DEF && b.skill < MAX_SKILLS_DEF)
          gain_mem[b.item][b.skill] = b.amount;
      end
      OP_SOLVE: cover_answers.push_back(cheapest_cover());
      default: ;
    endcase
  endfunction

  // input side: sample acceptance at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      absorb_beat(in_data);
      n_accepted++;
      beat_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      beat_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (item_queue.size() > 0) begin
        in_data  <= item_queue.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 99) < gap_pct) in_gap = $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < gap_pct) out_gap = $urandom_range(1, 5);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (cover_answers.size() == 0) begin
        report_mismatch($sformatf("result beat found=%0b min_cost=%0d with no solve pending",
                                  out_data.found, out_data.min_cost));
      end else begin
        next_answer = cover_answers.pop_front();
        if (next_answer.found) n_found++;
        if (out_data.found !== next_answer.found)
          report_mismatch($sformatf("found: got %0b, expected %0b",
                                    out_data.found, next_answer.found));
        if (out_data.min_cost !== next_answer.min_cost)
          report_mismatch($sformatf("min_cost: got %0d, expected %0d",
                                    out_data.min_cost, next_answer.min_cost));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SUM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NUM_ITEMS:  reg_items  = val[IDX_W-1:0];
      CFG_NUM_SKILLS: reg_skills = val[IDX_W-1:0];
      CFG_TARGET:     reg_target = val;
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_search(input logic [SUM_W-1:0] it, input logic [SUM_W-1:0] sk,
                            input logic [SUM_W-1:0] tgt);
    write_reg(CFG_NUM_ITEMS, it);
    write_reg(CFG_NUM_SKILLS, sk);
    write_reg(CFG_TARGET, tgt);
  endtask

  function automatic logic [AMT_W-1:0] rand_amount();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return AMT_W'($urandom_range(0, 65535));
  endfunction

  function automatic void queue_beat(input logic [OP_W-1:0] op, input int it, input int sk,
                                     input logic [AMT_W-1:0] amt);
    in_t b;
    b.operation = op;
    b.item      = it[IDX_W-1:0];
    b.skill     = sk[IDX_W-1:0];
    b.amount    = amt;
    item_queue.push_back(b);
  endfunction

  function automatic void queue_cost(input int it, input logic [AMT_W-1:0] amt);
    queue_beat(OP_COST, it, $urandom_range(0, 15), amt);
    if (it < MAX_ITEMS_DEF) begin
      cost_loaded[it] = 1'b1;
      n_useful++;
    end
  endfunction

  function automatic void queue_gain(input int it, input int sk, input logic [AMT_W-1:0] amt);
    queue_beat(OP_GAIN, it, sk, amt);
    if (it < MAX_ITEMS_DEF && sk < MAX_SKILLS_DEF) begin
      gain_loaded[it][sk] = 1'b1;
      n_useful++;
    end
  endfunction

  // fill every entry the next solve will read, then ask for it
  function automatic void queue_solve();
    int n_it, n_sk, i, j;
    n_it = clamp_count(reg_items, MAX_ITEMS_DEF);
    n_sk = clamp_count(reg_skills, MAX_SKILLS_DEF);
    for (i = 0; i < n_it; i++) begin
      if (!cost_loaded[i]) queue_cost(i, rand_amount());
      for (j = 0; j < n_sk; j++)
        if (!gain_loaded[i][j]) queue_gain(i, j, rand_amount());
    end
    queue_beat(OP_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
               AMT_W'($urandom_range(0, 65535)));
    n_useful++;
    n_solves++;
  endfunction

  task automatic drain();
    while (item_queue.size() != 0 || in_valid || cover_answers.size() != 0)
      @(posedge clk);
  endtask

  // drain, then let any trailing write or search finish before touching registers
  task automatic settle();
    drain();
    repeat ((1 << clamp_count(reg_items, MAX_ITEMS_DEF)) + 16) @(posedge clk);
  endtask

  task automatic run_phase(input int n_beats, input bit with_hold);
    int k, r, n_it, n_sk, pause_at;
    n_it = clamp_count(reg_items, MAX_ITEMS_DEF);
    n_sk = clamp_count(reg_skills, MAX_SKILLS_DEF);
    pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n_beats - 1) : -1;
    if (with_hold) begin
      hold_req = 1'b1;
      pause_at = n_beats / 2;
    end
    for (k = 0; k < n_beats; k++) begin
      if (k == pause_at) drain();
      r = $urandom_range(0, 99);
      if (r < 25 || (with_hold && r < 60)) begin
        queue_solve();
      end else if (r < 30) begin
        queue_beat(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                   AMT_W'($urandom_range(0, 65535)));
      end else if (r < 34) begin
        queue_cost($urandom_range(12, 15), rand_amount());
      end else if (r < 38) begin
        if ($urandom_range(0, 1))
          queue_gain($urandom_range(12, 15), $urandom_range(0, 15), rand_amount());
        else
          queue_gain($urandom_range(0, 11), $urandom_range(12, 15), rand_amount());
      end else if (r < 69) begin
        queue_cost((n_it > 0) ? $urandom_range(0, n_it - 1) : $urandom_range(0, 11),
                   rand_amount());
      end else begin
        queue_gain((n_it > 0) ? $urandom_range(0, n_it - 1) : $urandom_range(0, 11),
                   (n_sk > 0) ? $urandom_range(0, n_sk - 1) : $urandom_range(0, 11),
                   rand_amount());
      end
    end
    queue_solve();
  endtask

  initial begin
    int base, phase, r, it, sk, n_beats;
    logic [SUM_W-1:0] tgt;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // two items, one skill: only item 1 alone is the cheap cover
    set_search(2, 1, 10);
    queue_cost(0, 16'hFFFF);
    queue_cost(1, 5);
    queue_gain(0, 0, 16'hFFFF);
    queue_gain(1, 0, 10);
    queue_cost(11, 16'h0000);
    queue_gain(11, 11, 16'hFFFF);
    queue_beat(OP_UNUSED, 15, 15, 16'hFFFF);
    queue_cost(15, 16'h0000);
    queue_gain(0, 15, 16'h0000);
    queue_gain(15, 0, 16'h0000);
    queue_gain(12, 11, 16'h0000);
    queue_solve();
    settle();
    // target out of reach
    write_reg(CFG_TARGET, '1);
    queue_solve();
    settle();
    // no items: only the empty subset
    set_search(0, 1, 1);
    queue_solve();
    settle();
    // no skills: everything qualifies
    write_reg(CFG_NUM_SKILLS, 0);
    queue_solve();
    settle();
    write_reg(CFG_UNUSED, SUM_W'($urandom_range(0, 1048575)));
    set_search(1, 1, 0);
    queue_solve();

    base = n_useful;
    phase = 0;
    while (n_useful - base < 90 || n_solves < 25 || phase <= 6) begin
      settle();
      r = $urandom_range(0, 9);
      n_beats = $urandom_range(4, 10);
      if (phase == 1) begin
        it = 3;
        sk = 2;
        n_beats = 14;
      end else if (phase == 2) begin
        // item count above the table size: full search over every item
        it = 15;
        sk = 1;
        n_beats = 4;
      end else if (phase == 6) begin
        // skill count above the lane count: every lane must reach target
        it = 2;
        sk = $urandom_range(13, 15);
        n_beats = 4;
      end else begin
        it = (r == 0) ? $urandom_range(10, 11) :
             (r < 3)  ? $urandom_range(6, 9) : $urandom_range(1, 5);
        r = $urandom_range(0, 9);
        sk = (r == 0) ? 0 : $urandom_range(1, 4);
      end
      r = $urandom_range(0, 9);
      tgt = (r == 0) ? '0 : (r == 1) ? '1 :
            SUM_W'($urandom_range(0, clamp_count(it[IDX_W-1:0], MAX_ITEMS_DEF) * 40000));
      // upper data bits are junk for the count registers
      set_search({16'($urandom_range(0, 65535)), it[IDX_W-1:0]},
                 {16'($urandom_range(0, 65535)), sk[IDX_W-1:0]}, tgt);
      case ($urandom_range(0, 3))
        0: gap_pct = 0;
        1: gap_pct = 10;
        2: gap_pct = 25;
        default: gap_pct = 40;
      endcase
      run_phase(n_beats, phase == 1);
      phase++;
    end

    // closing stretch at full rate on both sides
    settle();
    set_search(4, 3, SUM_W'($urandom_range(0, 100000)));
    gap_pct = 0;
    run_phase(14, 1'b0);
    settle();

    $display("Run covered %0d input beats and %0d register writes over %0d search settings.",
             n_accepted, n_cfg_writes, phase + 6);
    $display("Checked %0d solve results, %0d of them with a qualifying subset.",
             n_checked, n_found);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mcsc_pkg.sv
hw/rtl/mcsc_ctrl.sv
hw/rtl/mcsc_dp.sv
hw/rtl/min_cost_subset_cover_search.sv
hw/rtl/mcsc_checker.sv
test/tb_min_cost_subset_cover_search.sv
